@@ rtl/fpm_pkg.sv @@
package fpm_pkg;

  // Menu levels
  typedef enum logic [1:0] {
    LVL_SPLASH,
    LVL_HOME,
    LVL_MAIN,
    LVL_SUB
  } level_t;

  // Item kinds (op field)
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TEMP = 1'b1;

  // Key codes
  localparam logic [7:0] KEY_ENTER = 8'd0;
  localparam logic [7:0] KEY_LEFT  = 8'd1;
  localparam logic [7:0] KEY_RIGHT = 8'd2;
  localparam logic [7:0] KEY_BACK  = 8'd3;

  // Buzzer commands
  localparam logic [1:0] BUZ_NONE = 2'd0;
  localparam logic [1:0] BUZ_ON   = 2'd1;
  localparam logic [1:0] BUZ_OFF  = 2'd2;

  // Page numbers
  localparam logic [3:0] PAGE_SPLASH    = 4'd0;
  localparam logic [3:0] PAGE_HOME      = 4'd1;
  localparam logic [3:0] PAGE_MAIN_BASE = 4'd2;
  localparam logic [3:0] PAGE_ALARM     = 4'd14;

  // Main entries
  localparam logic [1:0] MAIN_VERSION = 2'd3;

  // Configuration
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_THRESHOLD = 1'b0;
  localparam logic signed [15:0] THRESHOLD_RESET = 16'sd6000;

  // One input beat
  typedef struct packed {
    logic              op;
    logic [7:0]        key_code;
    logic signed [15:0] temperature;
  } item_t;

  // One result beat; page_valid in the lowest bit
  typedef struct packed {
    logic [1:0]  buzzer;
    logic        alarm_raised;
    logic [15:0] temp_word;
    logic        temp_valid;
    logic        show_version;
    logic [1:0]  scene;
    logic        scene_valid;
    logic        wake;
    logic [3:0]  page;
    logic        page_valid;
  } result_t;

  // Length of each entry's sub list
  function automatic logic [2:0] sub_len(input logic [1:0] m);
    logic [2:0] c;
    unique case (m)
      2'd0:    c = 3'd4;
      2'd1:    c = 3'd2;
      default: c = 3'd1;
    endcase
    return c;
  endfunction

  // Page of a sub list entry; out of list falls back to home
  function automatic logic [3:0] sub_page(input logic [1:0] m, input logic [1:0] s);
    logic [3:0] p;
    p = PAGE_HOME;
    if ({1'b0, s} < sub_len(m)) begin
      unique case (m)
        2'd0:    p = 4'd6 + {2'b00, s};
        2'd1:    p = 4'd10 + {2'b00, s};
        2'd2:    p = 4'd13;
        default: p = 4'd12;
      endcase
    end
    return p;
  endfunction

  // Sub index step right, wrapping inside the list
  function automatic logic [1:0] sub_right(input logic [1:0] m, input logic [1:0] s);
    logic [1:0] n;
    unique case (m)
      2'd0:    n = s + 2'd1;
      2'd1:    n = {1'b0, ~s[0]};
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // Sub index step left, wrapping inside the list
  function automatic logic [1:0] sub_left(input logic [1:0] m, input logic [1:0] s);
    logic [1:0] n;
    unique case (m)
      2'd0:    n = s - 2'd1;
      2'd1:    n = {1'b0, ~s[0]};
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // Page shown for a given menu position
  function automatic logic [3:0] page_of(input level_t lv, input logic [1:0] m,
                                         input logic [1:0] s);
    logic [3:0] p;
    unique case (lv)
      LVL_SPLASH: p = PAGE_SPLASH;
      LVL_HOME:   p = PAGE_HOME;
      LVL_MAIN:   p = PAGE_MAIN_BASE + {2'b00, m};
      default:    p = sub_page(m, s);
    endcase
    return p;
  endfunction

endpackage

@@ rtl/front_panel_menu_controller.sv @@
// Front panel menu controller.
// Slave stream: one beat per key press or temperature sample; tuser is the
// kind (0 key, 1 sample), tdata carries key code and temperature.
// Master stream: exactly one result beat per input beat, in order, with the
// page command, wake, scene, version, temperature and alarm fields.
// APB port: one register, the signed alarm threshold at address 0, written
// on the access cycle; pready is tied high and reads return the value.
// From input beat to result beat, a beat first waits in the input
// register, then the menu logic updates its state and loads the
// result register. One beat is taken every cycle while the receiver keeps
// tready high; the menu state registers close a loop on themselves, so the
// rate is set by that single next-state stage.
// When the receiver stalls, the result register holds and the input
// register fills, after which s_tready drops; nothing is lost.
// Reset (rst, synchronous) empties both registers, puts the menu at the
// splash level with indexes, lock and last temperature cleared, and loads
// the threshold with 60.00 degrees.
module front_panel_menu_controller (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,  // key_code[7:0], temperature[23:8]
  input  logic                           s_tuser,  // op
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // page_valid[0], page[4:1], wake[5], scene_valid[6], scene[8:7],
  // show_version[9], temp_valid[10], temp_word[26:11], alarm_raised[27],
  // buzzer[29:28], zero[31:30]
  output logic [31:0]                    m_tdata,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  fpm_pkg::item_t     in_item, held_item;
  fpm_pkg::result_t   result, out_result;
  logic               held_valid, fire, can_load;
  logic signed [15:0] alarm_threshold;

  assign in_item.op          = s_tuser;
  assign in_item.key_code    = s_tdata[7:0];
  assign in_item.temperature = s_tdata[23:8];

  // Threshold register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_threshold <= fpm_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == fpm_pkg::CFG_IDX_THRESHOLD) begin
      alarm_threshold <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == fpm_pkg::CFG_IDX_THRESHOLD)
                  ? {16'd0, alarm_threshold} : 32'd0;

  assign fire = held_valid && can_load;

  fpm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .take       (fire),
    .held_item  (held_item)
  );

  fpm_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .item            (held_item),
    .alarm_threshold (alarm_threshold),
    .result          (result)
  );

  fpm_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (held_valid),
    .can_load   (can_load),
    .result     (result),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tdata = {2'b00, out_result};

endmodule

@@ rtl/fpm_in_stage.sv @@
// Input register: holds one beat until the engine takes it
module fpm_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpm_pkg::item_t in_item,
  output logic           held_valid,
  input  logic           take,
  output fpm_pkg::item_t held_item
);

  assign in_ready = !held_valid || take;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

@@ rtl/fpm_engine.sv @@
// Menu state and result logic; state moves on each beat taken
module fpm_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  fpm_pkg::item_t           item,
  input  logic signed [15:0]       alarm_threshold,
  output fpm_pkg::result_t         result
);

  fpm_pkg::level_t    level, level_next;
  logic [1:0]         main_sel, main_sel_next;
  logic [1:0]         sub_sel, sub_sel_next;
  logic               alarm_lock, alarm_lock_next;
  logic signed [15:0] prev_temp, prev_temp_next;
  logic               issue;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= fpm_pkg::LVL_SPLASH;
      main_sel   <= 2'd0;
      sub_sel    <= 2'd0;
      alarm_lock <= 1'b0;
      prev_temp  <= 16'sd0;
    end else if (fire) begin
      level      <= level_next;
      main_sel   <= main_sel_next;
      sub_sel    <= sub_sel_next;
      alarm_lock <= alarm_lock_next;
      prev_temp  <= prev_temp_next;
    end
  end

  // Next state and result
  always_comb begin
    level_next      = level;
    main_sel_next   = main_sel;
    sub_sel_next    = sub_sel;
    alarm_lock_next = alarm_lock;
    prev_temp_next  = prev_temp;
    issue           = 1'b0;
    result          = '0;
    if (item.op == fpm_pkg::OP_KEY) begin
      result.wake = 1'b1;
      if (item.key_code == fpm_pkg::KEY_BACK) begin
        // back always works and silences a pending alarm
        issue = 1'b1;
        if (alarm_lock) begin
          result.buzzer   = fpm_pkg::BUZ_OFF;
          alarm_lock_next = 1'b0;
        end
        if (level == fpm_pkg::LVL_SUB) begin
          level_next = fpm_pkg::LVL_MAIN;
        end else if (level == fpm_pkg::LVL_MAIN) begin
          level_next = fpm_pkg::LVL_HOME;
        end
      end else if (item.key_code <= fpm_pkg::KEY_RIGHT && !alarm_lock) begin
        issue = 1'b1;
        priority if (item.key_code == fpm_pkg::KEY_ENTER) begin
          unique case (level)
            fpm_pkg::LVL_SPLASH: level_next = fpm_pkg::LVL_HOME;
            fpm_pkg::LVL_HOME: begin
              level_next    = fpm_pkg::LVL_MAIN;
              main_sel_next = 2'd0;
            end
            fpm_pkg::LVL_MAIN: begin
              level_next          = fpm_pkg::LVL_SUB;
              sub_sel_next        = 2'd0;
              result.show_version = (main_sel == fpm_pkg::MAIN_VERSION);
            end
            default: begin
              result.scene_valid = 1'b1;
              result.scene       = sub_sel;
            end
          endcase
        end else if (item.key_code == fpm_pkg::KEY_RIGHT) begin
          if (level == fpm_pkg::LVL_MAIN) begin
            main_sel_next = main_sel + 2'd1;
          end else if (level == fpm_pkg::LVL_SUB) begin
            sub_sel_next = fpm_pkg::sub_right(main_sel, sub_sel);
          end
        end else begin
          if (level == fpm_pkg::LVL_MAIN) begin
            main_sel_next = main_sel - 2'd1;
          end else if (level == fpm_pkg::LVL_SUB) begin
            sub_sel_next = fpm_pkg::sub_left(main_sel, sub_sel);
          end
        end
      end
      if (issue) begin
        result.page_valid = 1'b1;
        result.page       = fpm_pkg::page_of(level_next, main_sel_next, sub_sel_next);
      end
    end else begin
      // temperature sample: alarm on a rise to or past the threshold from at or below it
      result.temp_valid = 1'b1;
      result.temp_word  = item.temperature;
      prev_temp_next    = item.temperature;
      if (item.temperature >= alarm_threshold && prev_temp <= alarm_threshold) begin
        result.page_valid   = 1'b1;
        result.page         = fpm_pkg::PAGE_ALARM;
        result.alarm_raised = 1'b1;
        result.buzzer       = fpm_pkg::BUZ_ON;
        alarm_lock_next     = 1'b1;
      end
    end
  end

endmodule

@@ rtl/fpm_out_stage.sv @@
// Result register: holds one beat until the receiver takes it
module fpm_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  output logic             can_load,
  input  fpm_pkg::result_t result,
  output logic             out_valid,
  input  logic             out_ready,
  output fpm_pkg::result_t out_result
);

  assign can_load = !out_valid || out_ready;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_result <= result;
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import fpm_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_TAIL  = 8;

  // Menu model with the queue of results still due from the block
  class menu_scoreboard;
    result_t            due_results[$];
    logic signed [15:0] threshold;
    level_t             lvl;
    logic [1:0]         main_sel;
    logic [1:0]         sub_sel;
    logic               locked;
    logic [15:0]        prev_sample;
    int                 mismatches;

    function new();
      threshold   = THRESHOLD_RESET;
      lvl         = LVL_SPLASH;
      main_sel    = '0;
      sub_sel     = '0;
      locked      = 1'b0;
      prev_sample = '0;
      mismatches  = 0;
    endfunction

    function void set_threshold(logic signed [15:0] value);
      threshold = value;
    endfunction

    // Entries in each main entry's sub list
    function int list_len(logic [1:0] m);
      case (m)
        2'd0:    return 4;
        2'd1:    return 2;
        default: return 1;
      endcase
    endfunction

    function logic [3:0] shown_page();
      if (lvl == LVL_SPLASH) return PAGE_SPLASH;
      if (lvl == LVL_HOME) return PAGE_HOME;
      if (lvl == LVL_MAIN) return PAGE_MAIN_BASE + 4'(main_sel);
      // sub index past the end of its list falls back to home
      if (int'(sub_sel) >= list_len(main_sel)) return PAGE_HOME;
      case (main_sel)
        2'd0:    return 4'd6 + 4'(sub_sel);
        2'd1:    return 4'd10 + 4'(sub_sel);
        2'd2:    return 4'd13;
        default: return 4'd12;
      endcase
    endfunction

    // Work out the result of one accepted input beat and advance the menu
    function void note_beat(item_t it);
      result_t r;
      logic    issue;
      int      cnt;
      r     = '0;
      issue = 1'b0;
      cnt   = list_len(main_sel);
      if (it.op == OP_KEY) begin
        r.wake = 1'b1;
        if (it.key_code == KEY_BACK) begin
          if (locked) begin
            r.buzzer = BUZ_OFF;
            locked   = 1'b0;
          end
          if (lvl == LVL_SUB) lvl = LVL_MAIN;
          else if (lvl == LVL_MAIN) lvl = LVL_HOME;
          issue = 1'b1;
        end else if (it.key_code <= KEY_RIGHT && !locked) begin
          issue = 1'b1;
          case (it.key_code)
            KEY_ENTER: begin
              case (lvl)
                LVL_SPLASH: lvl = LVL_HOME;
                LVL_HOME: begin
                  lvl      = LVL_MAIN;
                  main_sel = '0;
                end
                LVL_MAIN: begin
                  lvl            = LVL_SUB;
                  sub_sel        = '0;
                  r.show_version = (main_sel == MAIN_VERSION);
                end
                default: begin
                  r.scene_valid = 1'b1;
                  r.scene       = sub_sel;
                end
              endcase
            end
            KEY_RIGHT: begin
              if (lvl == LVL_MAIN) main_sel = main_sel + 2'd1;
              else if (lvl == LVL_SUB) sub_sel = 2'((int'(sub_sel) % cnt + 1) % cnt);
            end
            default: begin
              if (lvl == LVL_MAIN) main_sel = main_sel - 2'd1;
              else if (lvl == LVL_SUB) sub_sel = 2'((int'(sub_sel) % cnt + cnt - 1) % cnt);
            end
          endcase
        end
        if (issue) begin
          r.page_valid = 1'b1;
          r.page       = shown_page();
        end
      end else begin
        r.temp_valid = 1'b1;
        r.temp_word  = it.temperature;
        // alarm on a rise to or past the threshold from at or below it
        if (it.temperature >= threshold && $signed(prev_sample) <= threshold) begin
          r.page_valid   = 1'b1;
          r.page         = PAGE_ALARM;
          r.alarm_raised = 1'b1;
          r.buzzer       = BUZ_ON;
          locked         = 1'b1;
        end
        prev_sample = it.temperature;
      end
      due_results.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf({"pv=%0b page=%0d wake=%0b sv=%0b scene=%0d ver=%0b tv=%0b",
                        " temp=%h alarm=%0b buz=%0d"},
                       r.page_valid, r.page, r.wake, r.scene_valid, r.scene,
                       r.show_version, r.temp_valid, r.temp_word, r.alarm_raised, r.buzzer);
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %s", show(got));
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  menu_scoreboard sb = new();
  logic           gaps_on = 1'b1;
  logic           hold_request = 1'b0;
  int             stuck_cycles = 0;

  front_panel_menu_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  function automatic item_t key_beat(logic [7:0] k);
    item_t it;
    it.op          = OP_KEY;
    it.key_code    = k;
    it.temperature = 16'($urandom());
    return it;
  endfunction

  function automatic item_t temp_beat(logic signed [15:0] t);
    item_t it;
    it.op          = OP_TEMP;
    it.key_code    = 8'($urandom());
    it.temperature = t;
    return it;
  endfunction

  // Offer one beat, with random idle cycles first, and note it once taken
  task automatic send_beat(item_t it);
    while (gaps_on && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {it.temperature, it.key_code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_beat(it);
  endtask

  // Mostly legal menu traffic, some stray keys, samples around the threshold
  task automatic send_random(int count);
    int roll;
    int near;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 18) send_beat(key_beat(KEY_ENTER));
      else if (roll < 33) send_beat(key_beat(KEY_RIGHT));
      else if (roll < 48) send_beat(key_beat(KEY_LEFT));
      else if (roll < 60) send_beat(key_beat(KEY_BACK));
      else if (roll < 68) send_beat(key_beat(8'($urandom_range(4, 255))));
      else begin
        roll = $urandom_range(0, 9);
        near = int'(sb.threshold) + int'($urandom_range(0, 400)) - 200;
        if (roll < 7) send_beat(temp_beat(16'(near)));
        else if (roll < 9) send_beat(temp_beat(16'($urandom())));
        else if ($urandom_range(0, 1)) send_beat(temp_beat(16'sh7fff));
        else send_beat(temp_beat(16'sh8000));
      end
    end
  endtask

  // Let every result come back before touching the register
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_threshold(logic signed [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_IDX_THRESHOLD, 2'b00};
    pwdata  <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_threshold(value);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      m_tready <= !(gaps_on && $urandom_range(0, 99) < 21);
    end
  end

  // Check each result beat against the oldest due result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(result_t'(m_tdata[29:0]));
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic signed [15:0] value;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_KEY;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through the menu at the reset threshold
    send_beat(key_beat(KEY_BACK));        // back at splash
    send_beat(key_beat(KEY_LEFT));        // arrows at splash
    send_beat(key_beat(KEY_RIGHT));
    send_beat(key_beat(8'hff));           // unknown key
    send_beat(key_beat(KEY_ENTER));       // to home
    send_beat(key_beat(KEY_LEFT));        // arrows and back at home
    send_beat(key_beat(KEY_RIGHT));
    send_beat(key_beat(KEY_BACK));
    send_beat(key_beat(KEY_ENTER));       // to main entry 0
    send_beat(key_beat(KEY_LEFT));        // wraps to version entry
    send_beat(key_beat(KEY_ENTER));       // version shown, sub level
    send_beat(key_beat(KEY_RIGHT));       // one-entry list
    send_beat(key_beat(KEY_ENTER));       // scene
    send_beat(key_beat(KEY_BACK));
    send_beat(key_beat(KEY_RIGHT));       // wraps to entry 0
    send_beat(key_beat(KEY_ENTER));
    send_beat(key_beat(KEY_LEFT));        // wraps to last sub page
    send_beat(key_beat(KEY_ENTER));
    send_beat(temp_beat(16'sh7fff));      // alarm, lock set
    send_beat(key_beat(KEY_ENTER));       // locked keys
    send_beat(key_beat(KEY_RIGHT));
    send_beat(temp_beat(16'sh8000));      // falls far below
    send_beat(temp_beat(THRESHOLD_RESET)); // exactly at threshold: alarm again
    send_beat(key_beat(KEY_BACK));        // clears lock, leaves sub level
    send_beat(key_beat(8'h80));
    send_random(250);

    // Further thresholds, extremes first
    for (int phase = 1; phase <= 6; phase++) begin
      drain();
      case (phase)
        1:       value = 16'sh8000;
        2:       value = 16'sh7fff;
        3:       value = 16'sd0;
        4:       value = 16'sd100;
        default: value = 16'($urandom());
      endcase
      write_threshold(value);
      if (phase == 1) hold_request = 1'b1;
      gaps_on = (phase != 3);
      send_random(230);
    end
    gaps_on = 1'b1;

    drain();
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fpm_pkg.sv
rtl/fpm_in_stage.sv
rtl/fpm_engine.sv
rtl/fpm_out_stage.sv
rtl/front_panel_menu_controller.sv
tb/tb.sv
